// File: design/msm_pkg.sv
package msm_pkg;

	// controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ZROW,
		ST_ADD,
		ST_TX_T,
		ST_TX_N,
		ST_B_RI,
		ST_B_RW,
		ST_B_DQ,
		ST_B_DQ2,
		ST_B_DQ3,
		ST_B_CI,
		ST_B_CW
	} state_t;

	// request codes
	localparam logic [2:0] REQ_CLEAR  = 3'd0;
	localparam logic [2:0] REQ_LETTER = 3'd1;
	localparam logic [2:0] REQ_END    = 3'd2;
	localparam logic [2:0] REQ_BUILD  = 3'd3;
	localparam logic [2:0] REQ_TEXT   = 3'd4;

	// result status codes
	localparam logic [1:0] STAT_MATCH   = 2'd0;
	localparam logic [1:0] STAT_BUILT   = 2'd1;
	localparam logic [1:0] STAT_REJECT  = 2'd2;
	localparam logic [1:0] STAT_NOBUILD = 2'd3;

	// most results one text letter may report
	localparam int MAX_RESULTS = 32;

	// field write enables of the node store
	typedef struct packed {
		logic mark;
		logic depth;
		logic dict;
		logic queue;
	} nwe_t;

endpackage

// File: design/msm_goto_ram.sv
module msm_goto_ram #(
	parameter int DEPTH = 26624,
	parameter int AW    = 15,
	parameter int DW    = 21
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr_a,
	output logic [DW-1:0] rdata_a,
	input  logic [AW-1:0] raddr_b,
	output logic [DW-1:0] rdata_b
);

	logic [DW-1:0] mem [DEPTH];

	// one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// File: design/multi_pattern_string_matcher.sv
// Aho-Corasick matcher built around a goto/transition memory and a node memory.
// Text letter: a goto read, then a node read, then a walk of the dictionary chain; handled
// in idle before a build or for a letter outside the alphabet.
// Pattern letter: handled in idle when ignored or failed, a goto and node read when the edge
// exists, and also a sweep of the new node's goto row when it makes a node.
// Build: a read and a write per slot of the root row, then for each other trie node a queue
// read, a failure-node read, a dictionary-link write and a read and a write per slot.
// Results appear in the cycle after they are found; the receiver cannot stall them.
// Reset and clear sweep the root row while busy stays high.
module multi_pattern_string_matcher #(
	parameter int MAX_STATES      = 1024,
	parameter int ALPHABET        = 26,
	parameter int MAX_PATTERNS    = 256,
	parameter int MAX_PATTERN_LEN = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  req_type,
	input  logic [4:0]  letter,
	input  logic        new_text,
	output logic        result_valid,
	output logic [1:0]  status,
	output logic [7:0]  pattern_id,
	output logic [31:0] position,
	output logic        last
);

	localparam int NW  = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
	localparam int SW  = $clog2(MAX_STATES * ALPHABET);
	localparam int AW  = $clog2(ALPHABET);
	localparam int GW  = 1 + 2 * NW;
	localparam int PW  = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
	localparam int CW  = $clog2(MAX_PATTERNS + 1);
	localparam int DPW = $clog2(MAX_PATTERN_LEN + 1);
	localparam int RW  = $clog2(msm_pkg::MAX_RESULTS + 1);

	typedef struct packed {
		logic           wend;
		logic [PW-1:0]  wnum;
		logic [DPW-1:0] depth;
		logic [NW-1:0]  dict;
		logic [NW-1:0]  qc;
		logic [NW-1:0]  qf;
	} node_t;

	function automatic logic [SW-1:0] slot_of(input logic [NW-1:0] node,
		input logic [SW-1:0] col);
		return SW'(node) * SW'(ALPHABET) + col;
	endfunction

	msm_pkg::state_t state_q, state_d;

	logic [AW-1:0] col_q, col_d;
	logic [NW-1:0] row_q, row_d;
	logic [NW:0]   next_free_q, next_free_d;
	logic [CW-1:0] count_q, count_d;
	logic [NW-1:0] cursor_q, cursor_d;
	logic          failed_q, failed_d;
	logic [NW-1:0] match_q, match_d;
	logic [31:0]   pos_q, pos_d;
	logic          built_q, built_d;
	logic [NW:0]   head_q, head_d;
	logic [NW:0]   tail_q, tail_d;
	logic [RW-1:0] nres_q, nres_d;
	logic [4:0]    letter_q, letter_d;
	logic [NW-1:0] u_q, u_d;
	logic [NW-1:0] fu_q, fu_d;
	logic [31:0]   tpos_q, tpos_d;

	// goto memory ports
	logic          g_we;
	logic [SW-1:0] g_wa, g_ra_a, g_ra_b;
	logic [GW-1:0] g_wd, g_rd_a, g_rd_b;
	logic          ga_v;
	logic [NW-1:0] ga_c, ga_t, gb_t;

	// node memory ports
	node_t          nmem [MAX_STATES];
	node_t          n_rd_q, n_wd;
	logic [NW-1:0]  n_ra, n_wa;
	msm_pkg::nwe_t  n_we;

	// result register inputs
	logic          res_v, res_last;
	logic [1:0]    res_status;
	logic [7:0]    res_id;
	logic [31:0]   res_pos;

	logic          accept, letter_ok, emit, at_limit;
	logic [NW-1:0] base_node;
	logic [31:0]   base_pos;

	msm_goto_ram #(
		.DEPTH (MAX_STATES * ALPHABET),
		.AW    (SW),
		.DW    (GW)
	) u_goto (
		.clk     (clk),
		.we      (g_we),
		.waddr   (g_wa),
		.wdata   (g_wd),
		.raddr_a (g_ra_a),
		.rdata_a (g_rd_a),
		.raddr_b (g_ra_b),
		.rdata_b (g_rd_b)
	);

	assign ga_v = g_rd_a[2*NW];
	assign ga_c = g_rd_a[2*NW-1:NW];
	assign ga_t = g_rd_a[NW-1:0];
	assign gb_t = g_rd_b[NW-1:0];

	// node memory with per-field write enables
	always_ff @(posedge clk) begin
		if (n_we.mark) begin
			nmem[n_wa].wend <= n_wd.wend;
			nmem[n_wa].wnum <= n_wd.wnum;
		end
		if (n_we.depth) begin
			nmem[n_wa].depth <= n_wd.depth;
		end
		if (n_we.dict) begin
			nmem[n_wa].dict <= n_wd.dict;
		end
		if (n_we.queue) begin
			nmem[n_wa].qc <= n_wd.qc;
			nmem[n_wa].qf <= n_wd.qf;
		end
		n_rd_q <= nmem[n_ra];
	end

	assign busy      = (state_q != msm_pkg::ST_IDLE);
	assign accept    = start && !busy;
	assign letter_ok = (32'(letter) < ALPHABET);
	assign base_node = new_text ? '0 : match_q;
	assign base_pos  = new_text ? '0 : pos_q;
	assign emit      = n_rd_q.wend;
	assign at_limit  = (32'(nres_q) + 1 >= msm_pkg::MAX_RESULTS);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= msm_pkg::ST_ZROW;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, memory control and results
	always_comb begin
		state_d     = state_q;
		col_d       = col_q;
		row_d       = row_q;
		next_free_d = next_free_q;
		count_d     = count_q;
		cursor_d    = cursor_q;
		failed_d    = failed_q;
		match_d     = match_q;
		pos_d       = pos_q;
		built_d     = built_q;
		head_d      = head_q;
		tail_d      = tail_q;
		nres_d      = nres_q;
		letter_d    = letter_q;
		u_d         = u_q;
		fu_d        = fu_q;
		tpos_d      = tpos_q;
		g_we        = 1'b0;
		g_wa        = '0;
		g_wd        = '0;
		g_ra_a      = '0;
		g_ra_b      = '0;
		n_ra        = '0;
		n_wa        = '0;
		n_we        = '0;
		n_wd        = '0;
		res_v       = 1'b0;
		res_status  = msm_pkg::STAT_MATCH;
		res_id      = '0;
		res_pos     = '0;
		res_last    = 1'b1;
		case (state_q)
			msm_pkg::ST_IDLE: begin
				if (accept) begin
					case (req_type)
						msm_pkg::REQ_CLEAR: begin
							next_free_d = (NW+1)'(1);
							count_d     = '0;
							cursor_d    = '0;
							failed_d    = 1'b0;
							match_d     = '0;
							pos_d       = '0;
							built_d     = 1'b0;
							row_d       = '0;
							col_d       = '0;
							state_d     = msm_pkg::ST_ZROW;
						end
						msm_pkg::REQ_LETTER: begin
							built_d = 1'b0;
							if (!failed_q) begin
								if (!letter_ok) begin
									failed_d = 1'b1;
								end else begin
									g_ra_a   = slot_of(cursor_q, SW'(letter));
									n_ra     = cursor_q;
									letter_d = letter;
									state_d  = msm_pkg::ST_ADD;
								end
							end
						end
						msm_pkg::REQ_END: begin
							cursor_d = '0;
							failed_d = 1'b0;
							if (failed_q || cursor_q == '0 || 32'(count_q) >= MAX_PATTERNS) begin
								res_v      = 1'b1;
								res_status = msm_pkg::STAT_REJECT;
							end else begin
								n_we.mark = 1'b1;
								n_wa      = cursor_q;
								n_wd.wend = 1'b1;
								n_wd.wnum = PW'(count_q);
								count_d   = count_q + 1'b1;
								built_d   = 1'b0;
							end
						end
						msm_pkg::REQ_BUILD: begin
							n_we.dict = 1'b1;
							n_wa      = '0;
							col_d     = '0;
							head_d    = '0;
							tail_d    = '0;
							state_d   = msm_pkg::ST_B_RI;
						end
						msm_pkg::REQ_TEXT: begin
							if (!built_q) begin
								res_v      = 1'b1;
								res_status = msm_pkg::STAT_NOBUILD;
								res_pos    = pos_q;
							end else begin
								pos_d = (base_pos == '1) ? base_pos : base_pos + 1'b1;
								if (!letter_ok) begin
									match_d = '0;
								end else begin
									g_ra_a  = slot_of(base_node, SW'(letter));
									tpos_d  = base_pos;
									nres_d  = '0;
									state_d = msm_pkg::ST_TX_T;
								end
							end
						end
						default: begin
						end
					endcase
				end
			end
			// clear one row of goto edges and the node's end mark; the root also gets its depth and dictionary link
			msm_pkg::ST_ZROW: begin
				g_we       = 1'b1;
				g_wa       = slot_of(row_q, SW'(col_q));
				n_wa       = row_q;
				n_we.mark  = 1'b1;
				n_we.depth = (row_q == '0);
				n_we.dict  = (row_q == '0);
				col_d      = col_q + 1'b1;
				if (col_q == AW'(ALPHABET - 1)) begin
					state_d = msm_pkg::ST_IDLE;
				end
			end
			msm_pkg::ST_ADD: begin
				state_d = msm_pkg::ST_IDLE;
				if (32'(n_rd_q.depth) >= MAX_PATTERN_LEN) begin
					failed_d = 1'b1;
				end else if (ga_v) begin
					cursor_d = ga_c;
				end else if (32'(next_free_q) >= MAX_STATES) begin
					failed_d = 1'b1;
				end else begin
					g_we        = 1'b1;
					g_wa        = slot_of(cursor_q, SW'(letter_q));
					g_wd        = {1'b1, next_free_q[NW-1:0], ga_t};
					n_we.depth  = 1'b1;
					n_wa        = next_free_q[NW-1:0];
					n_wd.depth  = n_rd_q.depth + 1'b1;
					cursor_d    = next_free_q[NW-1:0];
					next_free_d = next_free_q + 1'b1;
					row_d       = next_free_q[NW-1:0];
					col_d       = '0;
					state_d     = msm_pkg::ST_ZROW;
				end
			end
			msm_pkg::ST_TX_T: begin
				match_d = ga_t;
				n_ra    = ga_t;
				state_d = msm_pkg::ST_TX_N;
			end
			// walk the node reached and its dictionary chain
			msm_pkg::ST_TX_N: begin
				res_v      = emit;
				res_status = msm_pkg::STAT_MATCH;
				res_id     = 8'(n_rd_q.wnum);
				res_pos    = tpos_q;
				res_last   = (n_rd_q.dict == '0) || at_limit;
				if (emit) begin
					nres_d = nres_q + 1'b1;
				end
				n_ra = n_rd_q.dict;
				if (n_rd_q.dict == '0 || (emit && at_limit)) begin
					state_d = msm_pkg::ST_IDLE;
				end
			end
			msm_pkg::ST_B_RI: begin
				g_ra_a  = slot_of('0, SW'(col_q));
				state_d = msm_pkg::ST_B_RW;
			end
			// root row: children enter the queue with failure link root
			msm_pkg::ST_B_RW: begin
				g_we = 1'b1;
				g_wa = slot_of('0, SW'(col_q));
				g_wd = {ga_v, ga_c, (ga_v ? ga_c : NW'(0))};
				if (ga_v) begin
					n_we.queue = 1'b1;
					n_wa       = tail_q[NW-1:0];
					n_wd.qc    = ga_c;
					tail_d     = tail_q + 1'b1;
				end
				col_d = col_q + 1'b1;
				if (col_q == AW'(ALPHABET - 1)) begin
					state_d = msm_pkg::ST_B_DQ;
				end else begin
					state_d = msm_pkg::ST_B_RI;
				end
			end
			msm_pkg::ST_B_DQ: begin
				if (head_q == tail_q) begin
					built_d    = 1'b1;
					res_v      = 1'b1;
					res_status = msm_pkg::STAT_BUILT;
					state_d    = msm_pkg::ST_IDLE;
				end else begin
					n_ra    = head_q[NW-1:0];
					head_d  = head_q + 1'b1;
					state_d = msm_pkg::ST_B_DQ2;
				end
			end
			msm_pkg::ST_B_DQ2: begin
				u_d     = n_rd_q.qc;
				fu_d    = n_rd_q.qf;
				n_ra    = n_rd_q.qf;
				state_d = msm_pkg::ST_B_DQ3;
			end
			// dictionary link from the failure node
			msm_pkg::ST_B_DQ3: begin
				n_we.dict = 1'b1;
				n_wa      = u_q;
				n_wd.dict = n_rd_q.wend ? fu_q : n_rd_q.dict;
				col_d     = '0;
				state_d   = msm_pkg::ST_B_CI;
			end
			msm_pkg::ST_B_CI: begin
				g_ra_a  = slot_of(u_q, SW'(col_q));
				g_ra_b  = slot_of(fu_q, SW'(col_q));
				state_d = msm_pkg::ST_B_CW;
			end
			// child edge or borrowed transition of the failure node
			msm_pkg::ST_B_CW: begin
				g_we = 1'b1;
				g_wa = slot_of(u_q, SW'(col_q));
				g_wd = {ga_v, ga_c, (ga_v ? ga_c : gb_t)};
				if (ga_v) begin
					n_we.queue = 1'b1;
					n_wa       = tail_q[NW-1:0];
					n_wd.qc    = ga_c;
					n_wd.qf    = gb_t;
					tail_d     = tail_q + 1'b1;
				end
				col_d = col_q + 1'b1;
				if (col_q == AW'(ALPHABET - 1)) begin
					state_d = msm_pkg::ST_B_DQ;
				end else begin
					state_d = msm_pkg::ST_B_CI;
				end
			end
			default: begin
				state_d = msm_pkg::ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			next_free_q <= (NW+1)'(1);
			count_q     <= '0;
			cursor_q    <= '0;
			failed_q    <= 1'b0;
			match_q     <= '0;
			pos_q       <= '0;
			built_q     <= 1'b0;
			head_q      <= '0;
			tail_q      <= '0;
			nres_q      <= '0;
		end else begin
			col_q       <= col_d;
			row_q       <= row_d;
			next_free_q <= next_free_d;
			count_q     <= count_d;
			cursor_q    <= cursor_d;
			failed_q    <= failed_d;
			match_q     <= match_d;
			pos_q       <= pos_d;
			built_q     <= built_d;
			head_q      <= head_d;
			tail_q      <= tail_d;
			nres_q      <= nres_d;
		end
	end

	// working payload
	always_ff @(posedge clk) begin
		letter_q <= letter_d;
		u_q      <= u_d;
		fu_q     <= fu_d;
		tpos_q   <= tpos_d;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= res_v;
		end
	end

	always_ff @(posedge clk) begin
		if (res_v) begin
			status     <= res_status;
			pattern_id <= res_id;
			position   <= res_pos;
			last       <= res_last;
		end
	end

	a_queue_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == msm_pkg::ST_B_DQ) |-> (head_q <= tail_q))
		else $error("breadth queue head passed tail");

	a_node_limit: assert property (@(posedge clk) disable iff (!arst_n)
		32'(next_free_q) <= MAX_STATES)
		else $error("node allocation beyond trie capacity");

	a_result_limit: assert property (@(posedge clk) disable iff (!arst_n)
		32'(nres_q) <= msm_pkg::MAX_RESULTS)
		else $error("too many match results for one letter");

	a_match_built: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && status == msm_pkg::STAT_MATCH) |-> built_q)
		else $error("match reported without a built automaton");

endmodule
